// ===== design/amd_pkg.sv =====
package amd_pkg;

	localparam int MAP_SIDE    = 64;
	localparam int MAP_TOTAL   = MAP_SIDE * MAP_SIDE;
	localparam int POS_W       = $clog2(MAP_TOTAL + 1);
	localparam int COL_W       = $clog2(MAP_SIDE);
	localparam int BANK_DEPTH  = (MAP_SIDE + 1) / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int IDX_W       = 12;
	localparam int TDATA_OUT_W = 32;

	localparam logic [1:0] MODE_RLE  = 2'd0;
	localparam logic [1:0] MODE_RAW8 = 2'd1;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_SIDE - 1);
	localparam logic [COL_W-1:0] ROW_LAST = COL_W'(MAP_SIDE - 1);
	localparam logic [COL_W-1:0] ROW_KEEP = COL_W'(MAP_SIDE - 2);

	typedef enum logic [1:0] {
		PH_CTRL,
		PH_FILL,
		PH_COPY
	} rle_phase_t;

	typedef struct packed {
		logic [7:0]       a;
		logic [7:0]       b;
		logic [1:0]       cnt;
		logic [POS_W-1:0] pos;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] row_a;
		logic [COL_W-1:0] col_b;
		logic [COL_W-1:0] row_b;
		logic             rd_a;
		logic             rd_b;
		logic             last;
		logic             done;
	} emit_req_t;

	typedef struct packed {
		logic             en;
		logic             rd_b;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_b;
	} mem_rd_t;

	typedef struct packed {
		logic             en_a;
		logic [COL_W-1:0] col_a;
		logic [7:0]       data_a;
		logic             en_b;
		logic [COL_W-1:0] col_b;
		logic [7:0]       data_b;
	} mem_wr_t;

endpackage

// ===== design/amd_row_mem.sv =====
module amd_row_mem (
	input  logic            clk,
	input  amd_pkg::mem_rd_t rd,
	input  amd_pkg::mem_wr_t wr,
	output logic [7:0]      rd_data_a,
	output logic [7:0]      rd_data_b
);
	import amd_pkg::*;

	// two banks split by column parity: a pair of neighbors never shares a bank
	logic [7:0] ev_mem [BANK_DEPTH];
	logic [7:0] od_mem [BANK_DEPTH];

	logic [BANK_AW-1:0] ev_raddr, od_raddr, ev_waddr, od_waddr;
	logic [7:0]         ev_wdata, od_wdata;
	logic               ev_we, od_we;
	logic [7:0]         ev_q, od_q;
	logic               a_odd_q, b_odd_q;

	always_comb begin
		ev_raddr = (rd.rd_b && !rd.col_b[0]) ? BANK_AW'(rd.col_b >> 1) : BANK_AW'(rd.col_a >> 1);
		od_raddr = (rd.rd_b && rd.col_b[0]) ? BANK_AW'(rd.col_b >> 1) : BANK_AW'(rd.col_a >> 1);

		ev_we    = (wr.en_a && !wr.col_a[0]) || (wr.en_b && !wr.col_b[0]);
		od_we    = (wr.en_a && wr.col_a[0]) || (wr.en_b && wr.col_b[0]);
		ev_waddr = (wr.en_b && !wr.col_b[0]) ? BANK_AW'(wr.col_b >> 1) : BANK_AW'(wr.col_a >> 1);
		od_waddr = (wr.en_b && wr.col_b[0]) ? BANK_AW'(wr.col_b >> 1) : BANK_AW'(wr.col_a >> 1);
		ev_wdata = (wr.en_b && !wr.col_b[0]) ? wr.data_b : wr.data_a;
		od_wdata = (wr.en_b && wr.col_b[0]) ? wr.data_b : wr.data_a;
	end

	always_ff @(posedge clk) begin
		if (ev_we) begin
			ev_mem[ev_waddr] <= ev_wdata;
		end
		if (od_we) begin
			od_mem[od_waddr] <= od_wdata;
		end
		if (rd.en) begin
			ev_q    <= ev_mem[ev_raddr];
			od_q    <= od_mem[od_raddr];
			a_odd_q <= rd.col_a[0];
			b_odd_q <= rd.col_b[0];
		end
	end

	assign rd_data_a = a_odd_q ? od_q : ev_q;
	assign rd_data_b = b_odd_q ? od_q : ev_q;

endmodule

// ===== design/amd_ctrl.sv =====
module amd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              alpha_mode_we,
	input  logic [1:0]        alpha_mode,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        data_byte,
	input  logic              first_of_map,
	input  logic              fire_ok,
	output logic              req_valid,
	output amd_pkg::emit_req_t req,
	output amd_pkg::mem_rd_t  mem_rd
);
	import amd_pkg::*;

	logic [1:0]       mode_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [COL_W-1:0] col_q, col_n, row_q, row_n;
	rle_phase_t       phase_q, phase_n;
	logic [6:0]       rem_q, rem_n;
	logic             busy_q, busy_n;
	logic [7:0]       fbyte_q, fbyte_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RLE;
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= PH_CTRL;
			rem_q   <= '0;
			busy_q  <= 1'b0;
			fbyte_q <= '0;
		end else begin
			if (alpha_mode_we) begin
				mode_q <= alpha_mode;
			end
			pos_q   <= pos_n;
			col_q   <= col_n;
			row_q   <= row_n;
			phase_q <= phase_n;
			rem_q   <= rem_n;
			busy_q  <= busy_n;
			fbyte_q <= fbyte_n;
		end
	end

	always_comb begin
		logic             clr;
		logic [POS_W-1:0] pos_e, pos_adv;
		logic [COL_W-1:0] col_e, row_e, col1, row1, col2, row2;
		rle_phase_t       phase_e;
		logic [6:0]       rem_e, rem_left;
		logic             two_ok, fill_end;
		logic [7:0]       lo, hi;

		clr     = !busy_q && s_tvalid && first_of_map;
		pos_e   = clr ? '0 : pos_q;
		col_e   = clr ? '0 : col_q;
		row_e   = clr ? '0 : row_q;
		phase_e = clr ? PH_CTRL : phase_q;
		rem_e   = clr ? '0 : rem_q;

		col1    = (col_e == COL_LAST) ? '0 : col_e + 1'b1;
		row1    = (col_e == COL_LAST) ? row_e + 1'b1 : row_e;
		col2    = (col1 == COL_LAST) ? '0 : col1 + 1'b1;
		row2    = (col1 == COL_LAST) ? row1 + 1'b1 : row1;
		two_ok  = (pos_e + 1'b1) < POS_W'(MAP_TOTAL);
		lo      = {data_byte[3:0], data_byte[3:0]};
		hi      = {data_byte[7:4], data_byte[7:4]};

		pos_n    = pos_q;
		col_n    = col_q;
		row_n    = row_q;
		phase_n  = phase_q;
		rem_n    = rem_q;
		busy_n   = busy_q;
		fbyte_n  = fbyte_q;
		s_tready = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		req.cnt   = 2'd1;
		rem_left  = '0;
		fill_end  = 1'b0;

		if (busy_q) begin
			req_valid = 1'b1;
			req.a     = fbyte_q;
			req.b     = fbyte_q;
			req.cnt   = (|rem_q[6:1] && two_ok) ? 2'd2 : 2'd1;
			rem_left  = rem_q - 7'(req.cnt);
			fill_end  = (rem_left == '0) || (pos_e + POS_W'(req.cnt) == POS_W'(MAP_TOTAL));
			req.last  = fill_end;
			if (fire_ok) begin
				rem_n  = fill_end ? '0 : rem_left;
				busy_n = !fill_end;
			end
		end else begin
			s_tready = fire_ok;
			if (s_tvalid && fire_ok) begin
				pos_n   = pos_e;
				col_n   = col_e;
				row_n   = row_e;
				phase_n = phase_e;
				rem_n   = rem_e;
				if (pos_e < POS_W'(MAP_TOTAL)) begin
					req.last = 1'b1;
					if (mode_q == MODE_RLE) begin
						unique case (phase_e)
							PH_FILL: begin
								phase_n = PH_CTRL;
								if (rem_e != '0) begin
									busy_n  = 1'b1;
									fbyte_n = data_byte;
								end
							end
							PH_COPY: begin
								req_valid = 1'b1;
								req.a     = data_byte;
								rem_n     = rem_e - 1'b1;
								if (rem_n == '0) begin
									phase_n = PH_CTRL;
								end
							end
							default: begin
								rem_n = data_byte[6:0];
								if (data_byte[7]) begin
									phase_n = PH_FILL;
								end else if (data_byte[6:0] != '0) begin
									phase_n = PH_COPY;
								end else begin
									phase_n = PH_CTRL;
								end
							end
						endcase
					end else if (mode_q == MODE_RAW8) begin
						req_valid = 1'b1;
						req.a     = data_byte;
						req.rd_a  = (row_e == ROW_LAST);
					end else begin
						req_valid = 1'b1;
						req.cnt   = two_ok ? 2'd2 : 2'd1;
						req.a     = lo;
						req.b     = (col1 == COL_LAST) ? lo : hi;
						req.rd_a  = (row_e == ROW_LAST);
						req.rd_b  = two_ok && (row1 == ROW_LAST);
					end
				end
			end
		end

		req.pos   = pos_e;
		req.col_a = col_e;
		req.row_a = row_e;
		req.col_b = col1;
		req.row_b = row1;
		pos_adv   = pos_e + POS_W'(req.cnt);
		req.done  = (pos_adv == POS_W'(MAP_TOTAL));

		if (req_valid && fire_ok) begin
			pos_n = pos_adv;
			col_n = (req.cnt == 2'd2) ? col2 : col1;
			row_n = (req.cnt == 2'd2) ? row2 : row1;
		end

		mem_rd.en    = req_valid && fire_ok;
		mem_rd.rd_b  = req.rd_b;
		mem_rd.col_a = col_e;
		mem_rd.col_b = col1;
	end

endmodule

// ===== design/amd_out.sv =====
module amd_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  amd_pkg::emit_req_t         req,
	output logic                       fire_ok,
	input  logic [7:0]                 rd_data_a,
	input  logic [7:0]                 rd_data_b,
	output amd_pkg::mem_wr_t           mem_wr,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [amd_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);
	import amd_pkg::*;

	logic      valid_s1;
	emit_req_t req_s1;
	logic      s1_adv;
	logic [7:0] pix_a, pix_b;

	assign s1_adv  = valid_s1 && (!m_tvalid || m_tready);
	assign fire_ok = !valid_s1 || s1_adv;

	always_comb begin
		pix_a = req_s1.rd_a ? rd_data_a : req_s1.a;
		if (req_s1.cnt == 2'd2) begin
			pix_b = req_s1.rd_b ? rd_data_b : req_s1.b;
		end else begin
			pix_b = '0;
		end
		mem_wr.en_a   = s1_adv && (req_s1.row_a == ROW_KEEP);
		mem_wr.col_a  = req_s1.col_a;
		mem_wr.data_a = pix_a;
		mem_wr.en_b   = s1_adv && (req_s1.cnt == 2'd2) && (req_s1.row_b == ROW_KEEP);
		mem_wr.col_b  = req_s1.col_b;
		mem_wr.data_b = pix_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (fire_ok) begin
				valid_s1 <= req_valid;
			end
			if (s1_adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_ok && req_valid) begin
			req_s1 <= req;
		end
		if (s1_adv) begin
			m_tdata <= {2'b00, IDX_W'(req_s1.pos), req_s1.cnt, pix_b, pix_a};
			m_tlast <= req_s1.last;
			m_tuser <= req_s1.done;
		end
	end

endmodule

// ===== design/alpha_map_decoder.sv =====
// Alpha map decoder: takes the stored byte stream of one square alpha map
// (64x64 pixels) and emits its pixels in row-major order, one or two per output
// word with the index of the first. alpha_mode selects run-length (0), 8-bit
// (1) or 4-bit nibble (2, also 3) coding; the user must write it only while
// idle, which the block does not enforce. s_tuser marks the first byte of a map
// and restarts decoding. A fill byte holds off input while its run is emitted,
// as the output stage carries one pair per cycle unless m_tready stalls it;
// other bytes do not hold the input. Output words pass the request and output
// registers. Modes 1 to 3 read the last row back from a two-bank row memory
// written during the row before; past 4096 pixels, bytes are taken and dropped.
module alpha_map_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        alpha_mode_we,
	input  logic [1:0]  alpha_mode,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_of_map
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] pixel_first, [15:8] pixel_second,
	                               // [17:16] pixel_count, [29:18] pixel_index
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // [0] map_done
);
	import amd_pkg::*;

	logic      req_valid;
	emit_req_t req;
	mem_rd_t   mem_rd;
	mem_wr_t   mem_wr;
	logic      fire_ok;
	logic [7:0] rd_data_a, rd_data_b;

	amd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.alpha_mode_we(alpha_mode_we),
		.alpha_mode   (alpha_mode),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.data_byte    (s_tdata),
		.first_of_map (s_tuser),
		.fire_ok      (fire_ok),
		.req_valid    (req_valid),
		.req          (req),
		.mem_rd       (mem_rd)
	);

	amd_row_mem u_row_mem (
		.clk      (clk),
		.rd       (mem_rd),
		.wr       (mem_wr),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	amd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.fire_ok  (fire_ok),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.mem_wr   (mem_wr),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== design/amd_chk.sv =====
module amd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	import amd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:16] == 2'd1 || m_tdata[17:16] == 2'd2))
		else $error("pixel count out of range");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17:16] == 2'd1 |-> m_tdata[15:8] == 8'd0)
		else $error("second pixel not zero on single-pixel word");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("map done without run end");

	a_done_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[17:16] == 2'd2 |->
			m_tdata[29:18] == IDX_W'(MAP_TOTAL - 2))
		else $error("map done at wrong index");

endmodule

bind alpha_map_decoder amd_chk u_amd_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

// ===== test/alpha_map_decoder_tb.sv =====
`timescale 1ns / 1ps

module alpha_map_decoder_tb;
	import amd_pkg::*;

	localparam logic [1:0] MODE_NIB   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int SETTLE = 6;
	localparam int LIMIT  = 100000;

	typedef enum logic [1:0] {
		FEED_BYTE,
		FEED_MODE,
		FEED_DRAIN
	} feed_kind_t;

	typedef struct packed {
		feed_kind_t kind;
		logic [7:0] data;
		logic       first;
		logic [1:0] mode;
	} feed_t;

	typedef struct packed {
		logic [7:0]  first;
		logic [7:0]  second;
		logic [1:0]  cnt;
		logic [11:0] index;
		logic        last;
		logic        done;
	} pix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        alpha_mode_we = 1'b0;
	logic [1:0]  alpha_mode = MODE_RLE;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	feed_t feed_q[$];
	pix_t  pix_q[$];
	pix_t  byte_pix[$];

	// decoder state as seen by the predictor
	logic [7:0] row_keep [MAP_SIDE];
	int         out_pos = 0;
	rle_phase_t phase = PH_CTRL;
	int         run_left = 0;
	logic       run_fill = 1'b0;
	logic [1:0] mode_now = MODE_RLE;

	int  cyc = 0;
	int  quiet = 0;
	int  errors = 0;
	int  words_in = 0;
	int  checked = 0;
	int  maps_done = 0;
	logic [1:0] gen_mode = MODE_RLE;
	logic       gen_open = 1'b0;

	wire calm = (cyc >= 1200) && (cyc < 1700);

	alpha_map_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.alpha_mode_we(alpha_mode_we),
		.alpha_mode   (alpha_mode),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void put_pixels(input logic [7:0] a, input logic [7:0] b, input int cnt);
		pix_t w;
		w.first  = a;
		w.second = (cnt == 2) ? b : 8'd0;
		w.cnt    = 2'(cnt);
		w.index  = 12'(out_pos);
		w.last   = 1'b0;
		w.done   = (out_pos + cnt == MAP_TOTAL);
		if (out_pos / MAP_SIDE == MAP_SIDE - 2)
			row_keep[out_pos % MAP_SIDE] = a;
		if (cnt == 2 && (out_pos + 1) / MAP_SIDE == MAP_SIDE - 2)
			row_keep[(out_pos + 1) % MAP_SIDE] = b;
		out_pos += cnt;
		byte_pix = {byte_pix, w};
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic first);
		logic [7:0] lo, hi, pa, pb;
		int p1, cnt;
		pix_t w;
		if (first) begin
			out_pos  = 0;
			phase    = PH_CTRL;
			run_left = 0;
			run_fill = 1'b0;
		end
		if (out_pos < MAP_TOTAL) begin
			lo = {4'd0, b[3:0]} * 8'd17;
			hi = {4'd0, b[7:4]} * 8'd17;
			p1 = out_pos + 1;
			if (mode_now == MODE_RLE) begin
				case (phase)
				PH_FILL: begin
					while (run_left > 0 && out_pos < MAP_TOTAL) begin
						cnt = (run_left >= 2 && out_pos + 1 < MAP_TOTAL) ? 2 : 1;
						put_pixels(b, b, cnt);
						run_left -= cnt;
					end
					run_left = 0;
					phase = PH_CTRL;
				end
				PH_COPY: begin
					put_pixels(b, 8'd0, 1);
					run_left = (run_left - 1) & 127;
					if (run_left == 0)
						phase = PH_CTRL;
				end
				default: begin
					run_fill = b[7];
					run_left = int'(b[6:0]);
					if (run_fill)
						phase = PH_FILL;
					else if (run_left != 0)
						phase = PH_COPY;
					else
						phase = PH_CTRL;
				end
				endcase
			end else if (mode_now == MODE_RAW8) begin
				if (out_pos / MAP_SIDE == MAP_SIDE - 1)
					pa = row_keep[out_pos % MAP_SIDE];
				else
					pa = b;
				put_pixels(pa, 8'd0, 1);
			end else begin
				cnt = (p1 < MAP_TOTAL) ? 2 : 1;
				if (out_pos / MAP_SIDE == MAP_SIDE - 1)
					pa = row_keep[out_pos % MAP_SIDE];
				else
					pa = lo;
				if (p1 / MAP_SIDE == MAP_SIDE - 1)
					pb = row_keep[p1 % MAP_SIDE];
				else if (p1 % MAP_SIDE == MAP_SIDE - 1)
					pb = lo;
				else
					pb = hi;
				put_pixels(pa, pb, cnt);
			end
		end
		while (byte_pix.size() > 0) begin
			w = byte_pix.pop_front();
			w.last = (byte_pix.size() == 0);
			pix_q = {pix_q, w};
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic first);
		feed_t f;
		f.kind  = FEED_BYTE;
		f.data  = b;
		f.first = first;
		f.mode  = MODE_RLE;
		feed_q = {feed_q, f};
	endtask

	task automatic put_mode(input logic [1:0] m);
		feed_t f;
		f.kind  = FEED_MODE;
		f.data  = 8'd0;
		f.first = 1'b0;
		f.mode  = m;
		feed_q = {feed_q, f};
		gen_mode = m;
	endtask

	task automatic put_drain();
		feed_t f;
		f.kind  = FEED_DRAIN;
		f.data  = 8'd0;
		f.first = 1'b0;
		f.mode  = MODE_RLE;
		feed_q = {feed_q, f};
	endtask

	// whole map: fills into row 62, nibbles over the row end, 8-bit in the last row,
	// then a run cut by the end and a few dropped bytes
	task automatic finish_map(input logic odd);
		int pos, c, rem, stop, n;
		pos = 0;
		put_mode(MODE_RLE);
		stop = MAP_TOTAL - MAP_SIDE - 2 * $urandom_range(1, 3) - int'(odd);
		while (pos < stop) begin
			c = (stop - pos > 127) ? 127 : stop - pos;
			put_byte({1'b1, 7'(c)}, pos == 0);
			put_byte(8'($urandom), 1'b0);
			pos += c;
		end
		put_mode(MODE_NIB);
		n = $urandom_range(4, 5);
		repeat (n) put_byte(8'($urandom), 1'b0);
		pos += 2 * n;
		put_mode(MODE_RAW8);
		n = $urandom_range(2, 4);
		repeat (n) put_byte(8'($urandom), 1'b0);
		pos += n;
		put_mode(MODE_RLE);
		rem = MAP_TOTAL - pos;
		if ($urandom_range(0, 1)) begin
			put_byte(8'hFF, 1'b0);
			put_byte(8'($urandom), 1'b0);
		end else begin
			put_byte({1'b1, 7'(rem - 3)}, 1'b0);
			put_byte(8'($urandom), 1'b0);
			put_byte(8'h05, 1'b0);
			repeat (5) put_byte(8'($urandom), 1'b0);
		end
		repeat (2) put_byte(8'($urandom), 1'b0);
		gen_open = 1'b0;
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cyc, pix_q.size());
			$display("** alpha_map_decoder: FAILED **");
			$finish;
		end
	end

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid      <= 1'b0;
			s_tdata       <= 8'd0;
			s_tuser       <= 1'b0;
			alpha_mode_we <= 1'b0;
			alpha_mode    <= MODE_RLE;
			quiet         <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tuser);
				words_in++;
			end
			quiet <= (s_tvalid || pix_q.size() != 0) ? 0 : ((quiet < SETTLE) ? quiet + 1 : quiet);
			if (s_tvalid && !s_tready) begin
				alpha_mode_we <= 1'b0;
			end else if (feed_q.size() == 0) begin
				s_tvalid      <= 1'b0;
				alpha_mode_we <= 1'b0;
			end else if (feed_q[0].kind == FEED_BYTE) begin
				alpha_mode_we <= 1'b0;
				if (!calm && $urandom_range(0, 99) < 21) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= feed_q[0].data;
					s_tuser  <= feed_q[0].first;
					feed_q.delete(0);
				end
			end else begin
				s_tvalid <= 1'b0;
				if (quiet >= SETTLE && feed_q[0].kind == FEED_MODE) begin
					alpha_mode_we <= 1'b1;
					alpha_mode    <= feed_q[0].mode;
					mode_now = feed_q[0].mode;
					feed_q.delete(0);
				end else begin
					alpha_mode_we <= 1'b0;
					if (quiet >= SETTLE)
						feed_q.delete(0);
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pix_q.size() == 0) begin
					$error("output word with nothing expected: tdata %h", m_tdata);
					errors++;
				end else begin
					want = pix_q.pop_front();
					check_field("pixel_first", want.first, m_tdata[7:0]);
					check_field("pixel_second", want.second, m_tdata[15:8]);
					check_field("pixel_count", want.cnt, m_tdata[17:16]);
					check_field("pixel_index", want.index, m_tdata[29:18]);
					check_field("run_last", want.last, m_tlast);
					check_field("map_done", want.done, m_tuser);
					checked++;
					if (want.done)
						maps_done++;
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 21);
		end
	end

	initial begin
		int pick, c, k, rand_bytes;
		logic start;

		// run-length from reset mode: fills, copies, zero counts, longest fill
		put_byte(8'h85, 1'b1);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h03, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h5A, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'hAA, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h02, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h7F, 1'b0);
		// mode changes mid-map, nibbles on an odd position
		put_mode(MODE_RAW8);
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h55, 1'b0);
		put_byte(8'h0F, 1'b0);
		put_mode(MODE_NIB);
		put_byte(8'h0F, 1'b0);
		put_byte(8'hF0, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_mode(MODE_SPARE);
		put_byte(8'h3C, 1'b0);
		put_byte(8'h12, 1'b1);
		gen_open = 1'b1;

		// complete map: last row, column 63, cut runs, bytes after the end
		finish_map(1'($urandom_range(0, 1)));

		rand_bytes = 0;
		while (rand_bytes < 12) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				put_mode(2'($urandom_range(0, 3)));
			end else if (pick == 2) begin
				put_drain();
			end else if (pick < 6) begin
				put_byte(8'($urandom), $urandom_range(0, 3) == 0);
				rand_bytes++;
			end else begin
				start = !gen_open || $urandom_range(0, 15) == 0;
				gen_open = 1'b1;
				if (gen_mode == MODE_RLE) begin
					if ($urandom_range(0, 1)) begin
						c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
						put_byte({1'b1, 7'(c)}, start);
						put_byte(8'($urandom), 1'b0);
						rand_bytes += 2;
					end else begin
						c = $urandom_range(0, 4);
						put_byte({1'b0, 7'(c)}, start);
						repeat (c) put_byte(8'($urandom), 1'b0);
						rand_bytes += c + 1;
					end
				end else begin
					c = $urandom_range(1, 4);
					for (k = 0; k < c; k++)
						put_byte(8'($urandom), start && k == 0);
					rand_bytes += c;
				end
			end
		end
		put_drain();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (feed_q.size() != 0 || s_tvalid || pix_q.size() != 0);
		repeat (20) @(negedge clk);

		$display("%0d bytes in, %0d output words checked, %0d maps completed, modes 0 to 3",
			words_in, checked, maps_done);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("** alpha_map_decoder: PASSED **");
		else
			$display("** alpha_map_decoder: FAILED **");
		$finish;
	end

endmodule
